// ===== src/lisc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lisc_pkg
// Shared types and defaults of the longest increasing subsequence core.
// ----------------------------------------------------------------------------
package lisc_pkg;

  // Default store depth and value width
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int VALUE_WIDTH_DEF  = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DP_OUTER,
    ST_DP_PIVOT,
    ST_DP_INNER,
    ST_SCAN,
    ST_TRACE,
    ST_EM_TRACE,
    ST_EM_VALUE,
    ST_EM_OUT
  } lisc_state_t;

  // Result strobe and flags from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic last_mark;
    logic dropped;
  } lisc_emit_t;

endpackage
`default_nettype wire

// ===== src/lisc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lisc_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module lisc_ram import lisc_pkg::*; #(
  parameter  int DEPTH = MAX_ELEMENTS_DEF,
  parameter  int WIDTH = VALUE_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/lisc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lisc_seq
// Sequencer and datapath: loads the sequence, runs the quadratic run-length
// pass over the memories, finds the longest run, traces it back and steps
// through the result elements.
// ----------------------------------------------------------------------------
module lisc_seq import lisc_pkg::*; #(
  parameter  int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter  int VALUE_WIDTH  = VALUE_WIDTH_DEF,
  localparam int IDX_W        = $clog2(MAX_ELEMENTS),
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input transaction
  input  wire logic                   in_valid,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   in_last,
  output logic                        in_ready,
  // output register handoff
  input  wire logic                   out_free,
  output lisc_emit_t                  emit,
  output logic      [IDX_W-1:0]       emit_pos,
  output logic      [LEN_W-1:0]       emit_len,
  // value memory
  output logic                        vram_we,
  output logic      [IDX_W-1:0]       vram_waddr,
  output logic      [VALUE_WIDTH-1:0] vram_wdata,
  output logic                        vram_re,
  output logic      [IDX_W-1:0]       vram_raddr,
  input  wire logic [VALUE_WIDTH-1:0] vram_rdata,
  // run length memory
  output logic                        lram_we,
  output logic      [IDX_W-1:0]       lram_waddr,
  output logic      [LEN_W-1:0]       lram_wdata,
  output logic                        lram_re,
  output logic      [IDX_W-1:0]       lram_raddr,
  input  wire logic [LEN_W-1:0]       lram_rdata,
  // trace memory
  output logic                        tram_we,
  output logic      [IDX_W-1:0]       tram_waddr,
  output logic      [IDX_W-1:0]       tram_wdata,
  output logic                        tram_re,
  output logic      [IDX_W-1:0]       tram_raddr,
  input  wire logic [IDX_W-1:0]       tram_rdata
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ELEMENTS);
  localparam logic [LEN_W-1:0] ONE     = LEN_W'(1);
  localparam logic [LEN_W-1:0] TWO     = LEN_W'(2);

  lisc_state_t state_r, state_nxt;

  // control registers
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pj_r, pj_nxt;
  logic             go_r, go_nxt;

  // payload registers
  logic [VALUE_WIDTH-1:0] piv_val_r, piv_val_nxt;
  logic [LEN_W-1:0]       piv_len_r, piv_len_nxt;
  logic [LEN_W-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]       first_r, first_nxt;
  logic [LEN_W-1:0]       want_r, want_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;

  logic             in_acc;
  logic             full;
  logic             j_lt;
  logic             inner_done;
  logic             scan_done;
  logic             trace_done;
  logic             dp_hit;
  logic             tr_hit;
  logic             last_elem;
  logic [LEN_W-1:0] i_plus2;
  logic [LEN_W-1:0] want_dec;

  assign in_acc     = in_valid && in_ready;
  assign full       = (cnt_r == MAX_LEN);
  assign j_lt       = (j_r < cnt_r);
  assign inner_done = !j_lt && !pv_r;
  assign scan_done  = !j_lt && !pv_r;
  assign trace_done = !go_r && !pv_r;
  assign i_plus2    = i_r + TWO;
  assign want_dec   = want_r - ONE;
  assign last_elem  = ((k_r + ONE) == best_r);
  assign dp_hit     = ($signed(vram_rdata) > $signed(piv_val_r)) && (lram_rdata <= piv_len_r);
  assign tr_hit     = (want_r != '0) && (lram_rdata == want_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_last) begin
          state_nxt = (cnt_r != '0) ? ST_DP_OUTER : ST_SCAN;
        end
      end
      ST_DP_OUTER: state_nxt = ST_DP_PIVOT;
      ST_DP_PIVOT: state_nxt = ST_DP_INNER;
      ST_DP_INNER: begin
        if (inner_done) begin
          state_nxt = (i_plus2 < cnt_r) ? ST_DP_OUTER : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_TRACE;
        end
      end
      ST_TRACE: begin
        if (trace_done) begin
          state_nxt = ST_EM_TRACE;
        end
      end
      ST_EM_TRACE: state_nxt = ST_EM_VALUE;
      ST_EM_VALUE: state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (out_free) begin
          state_nxt = last_elem ? ST_LOAD : ST_EM_TRACE;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Memory controls, handshake and result strobe
  always_comb begin
    in_ready   = (state_r == ST_LOAD);

    vram_we    = (state_r == ST_LOAD) && in_acc && !full;
    vram_waddr = cnt_r[IDX_W-1:0];
    vram_wdata = in_value;
    vram_re    = 1'b0;
    vram_raddr = j_r[IDX_W-1:0];

    lram_we    = 1'b0;
    lram_waddr = pj_r;
    lram_wdata = piv_len_r + ONE;
    lram_re    = 1'b0;
    lram_raddr = j_r[IDX_W-1:0];

    tram_we    = (state_r == ST_TRACE) && pv_r && tr_hit;
    tram_waddr = want_dec[IDX_W-1:0];
    tram_wdata = pj_r;
    tram_re    = (state_r == ST_EM_TRACE);
    tram_raddr = k_r[IDX_W-1:0];

    unique case (state_r)
      ST_LOAD: begin
        // seed the run length of each stored element with one
        lram_we    = in_acc && !full;
        lram_waddr = cnt_r[IDX_W-1:0];
        lram_wdata = ONE;
      end
      ST_DP_OUTER: begin
        vram_re    = 1'b1;
        vram_raddr = i_r[IDX_W-1:0];
        lram_re    = 1'b1;
        lram_raddr = i_r[IDX_W-1:0];
      end
      ST_DP_INNER: begin
        vram_re = j_lt;
        lram_re = j_lt;
        lram_we = pv_r && dp_hit;
      end
      ST_SCAN: begin
        lram_re = j_lt;
      end
      ST_TRACE: begin
        lram_re = go_r;
      end
      ST_EM_VALUE: begin
        vram_re    = 1'b1;
        vram_raddr = tram_rdata;
      end
      default: begin
      end
    endcase

    emit.load      = (state_r == ST_EM_OUT) && out_free;
    emit.last_mark = last_elem;
    emit.dropped   = ovf_r;
    emit_pos       = pos_r;
    emit_len       = best_r;
  end

  // Datapath next values
  always_comb begin
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    pv_nxt      = pv_r;
    pj_nxt      = pj_r;
    go_nxt      = go_r;
    piv_val_nxt = piv_val_r;
    piv_len_nxt = piv_len_r;
    best_nxt    = best_r;
    first_nxt   = first_r;
    want_nxt    = want_r;
    pos_nxt     = pos_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            cnt_nxt = cnt_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt     = '0;
            j_nxt     = '0;
            pv_nxt    = 1'b0;
            best_nxt  = '0;
            first_nxt = '0;
          end
        end
      end
      ST_DP_PIVOT: begin
        // hold the outer element for the inner sweep
        piv_val_nxt = vram_rdata;
        piv_len_nxt = lram_rdata;
        j_nxt       = i_r + ONE;
        pv_nxt      = 1'b0;
      end
      ST_DP_INNER: begin
        pv_nxt = j_lt;
        pj_nxt = j_r[IDX_W-1:0];
        if (j_lt) begin
          j_nxt = j_r + ONE;
        end
        if (inner_done) begin
          i_nxt     = i_r + ONE;
          j_nxt     = '0;
          best_nxt  = '0;
          first_nxt = '0;
        end
      end
      ST_SCAN: begin
        pv_nxt = j_lt;
        pj_nxt = j_r[IDX_W-1:0];
        if (j_lt) begin
          j_nxt = j_r + ONE;
        end
        // keep the first position that reaches a new maximum
        if (pv_r && (lram_rdata > best_r)) begin
          best_nxt  = lram_rdata;
          first_nxt = pj_r;
        end
        if (scan_done) begin
          j_nxt    = LEN_W'(first_r);
          go_nxt   = 1'b1;
          want_nxt = best_r;
        end
      end
      ST_TRACE: begin
        // walk down from the first maximum
        pv_nxt = go_r;
        pj_nxt = j_r[IDX_W-1:0];
        if (go_r) begin
          if (j_r == '0) begin
            go_nxt = 1'b0;
          end else begin
            j_nxt = j_r - ONE;
          end
        end
        if (pv_r && tr_hit) begin
          want_nxt = want_dec;
        end
        if (trace_done) begin
          k_nxt = '0;
        end
      end
      ST_EM_VALUE: begin
        pos_nxt = tram_rdata;
      end
      ST_EM_OUT: begin
        if (out_free) begin
          if (last_elem) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end else begin
            k_nxt = k_r + ONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      pv_r    <= 1'b0;
      pj_r    <= '0;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      pv_r    <= pv_nxt;
      pj_r    <= pj_nxt;
      go_r    <= go_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    piv_val_r <= piv_val_nxt;
    piv_len_r <= piv_len_nxt;
    best_r    <= best_nxt;
    first_r   <= first_nxt;
    want_r    <= want_nxt;
    pos_r     <= pos_nxt;
  end

  // A run length write never lands on the entry read in the same cycle
  a_rl_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (lram_we && lram_re) |-> (lram_waddr != lram_raddr))
    else $error("run length write collides with read");

  // The fill count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_LEN)
    else $error("fill count beyond store depth");

  // The scan always finds a run of at least one
  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_done) |-> (best_r != '0))
    else $error("scan ended with zero length");

  // The trace back places every element of the longest run
  a_trace_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRACE && trace_done) |-> (want_r == '0))
    else $error("trace back left elements unplaced");

endmodule
`default_nettype wire

// ===== src/longest_increasing_subsequence_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_core
// Loads a signed sequence, finds one longest strictly increasing
// subsequence with the quadratic run-length method and streams it out.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------------
//   in_     | input     | in_valid / in_ready  | value, last
//   out_    | output    | out_valid / out_ready| element, position, lis_length,
//           |           |                      | dropped, last_out
//
// Load stores each accepted value until the store is full. On the last one the
// run-length pass sweeps the memories, one compare per cycle of each inner sweep
// through the run length memory port, then scans for the maximum and traces it
// back. Each result is fetched by a trace memory read and then a value memory
// read; the output register lets the next result be fetched while one waits.
// Reset clears the control state only; the memories need no clearing pass.
// Input is taken only while loading.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_core import lisc_pkg::*; #(
  parameter  int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter  int VALUE_WIDTH  = VALUE_WIDTH_DEF,
  localparam int IDX_W        = $clog2(MAX_ELEMENTS),
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   in_last,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [VALUE_WIDTH-1:0] out_element,
  output logic      [IDX_W-1:0]       out_position,
  output logic      [LEN_W-1:0]       out_lis_length,
  output logic                        out_dropped,
  output logic                        out_last_out
);

  lisc_emit_t emit;
  logic [IDX_W-1:0] emit_pos;
  logic [LEN_W-1:0] emit_len;
  logic             out_free;

  logic                   vram_we, vram_re;
  logic [IDX_W-1:0]       vram_waddr, vram_raddr;
  logic [VALUE_WIDTH-1:0] vram_wdata, vram_rdata;
  logic                   lram_we, lram_re;
  logic [IDX_W-1:0]       lram_waddr, lram_raddr;
  logic [LEN_W-1:0]       lram_wdata, lram_rdata;
  logic                   tram_we, tram_re;
  logic [IDX_W-1:0]       tram_waddr, tram_raddr;
  logic [IDX_W-1:0]       tram_wdata, tram_rdata;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_element_r;
  logic [IDX_W-1:0]       out_position_r;
  logic [LEN_W-1:0]       out_lis_length_r;
  logic                   out_dropped_r;
  logic                   out_last_out_r;

  assign out_free = !out_valid_r || out_ready;

  lisc_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_value   (in_value),
    .in_last    (in_last),
    .in_ready   (in_ready),
    .out_free   (out_free),
    .emit       (emit),
    .emit_pos   (emit_pos),
    .emit_len   (emit_len),
    .vram_we    (vram_we),
    .vram_waddr (vram_waddr),
    .vram_wdata (vram_wdata),
    .vram_re    (vram_re),
    .vram_raddr (vram_raddr),
    .vram_rdata (vram_rdata),
    .lram_we    (lram_we),
    .lram_waddr (lram_waddr),
    .lram_wdata (lram_wdata),
    .lram_re    (lram_re),
    .lram_raddr (lram_raddr),
    .lram_rdata (lram_rdata),
    .tram_we    (tram_we),
    .tram_waddr (tram_waddr),
    .tram_wdata (tram_wdata),
    .tram_re    (tram_re),
    .tram_raddr (tram_raddr),
    .tram_rdata (tram_rdata)
  );

  // Loaded values
  lisc_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (VALUE_WIDTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (vram_re),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  // Run lengths
  lisc_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (LEN_W)
  ) u_length_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (lram_waddr),
    .wdata (lram_wdata),
    .re    (lram_re),
    .raddr (lram_raddr),
    .rdata (lram_rdata)
  );

  // Trace back positions
  lisc_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (IDX_W)
  ) u_trace_ram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tram_waddr),
    .wdata (tram_wdata),
    .re    (tram_re),
    .raddr (tram_raddr),
    .rdata (tram_rdata)
  );

  // Output valid: set on load, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_element_r    <= vram_rdata;
      out_position_r   <= emit_pos;
      out_lis_length_r <= emit_len;
      out_dropped_r    <= emit.dropped;
      out_last_out_r   <= emit.last_mark;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_element    = out_element_r;
  assign out_position   = out_position_r;
  assign out_lis_length = out_lis_length_r;
  assign out_dropped    = out_dropped_r;
  assign out_last_out   = out_last_out_r;

endmodule
`default_nettype wire

// ===== dv/tb_longest_increasing_subsequence_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_increasing_subsequence_core
// Streams signed sequences into the core and checks each emitted subsequence
// element against a behavioral longest-increasing-subsequence tracker. A short
// table of directed sequences comes first, then random sequences of mixed
// length, including full and overflowing stores, under varying flow control.
// ----------------------------------------------------------------------------
module tb_longest_increasing_subsequence_core;
  import lisc_pkg::*;

  localparam int VW    = VALUE_WIDTH_DEF;
  localparam int DEPTH = MAX_ELEMENTS_DEF;
  localparam int IW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 296;
  localparam int TABLE_ROWS   = 23;

  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VAL_NEG1 = {VW{1'b1}};

  typedef struct packed {
    logic [VW-1:0] element;
    logic [IW-1:0] position;
    logic [LW-1:0] lis_length;
    logic          dropped;
    logic          last_out;
  } lis_result_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          last;
    logic          typed;
    lis_result_t   res;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [VW-1:0] in_value = '0;
  logic          in_last = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [VW-1:0] out_element;
  logic [IW-1:0] out_position;
  logic [LW-1:0] out_lis_length;
  logic          out_dropped;
  logic          out_last_out;

  // Sequence currently being loaded, as the core should hold it
  logic signed [VW-1:0] loaded_vals[$];
  bit                   store_overflow;
  lis_result_t          lis_expect_q[$];

  int fail_count    = 0;
  int idle_in_pct   = 0;
  int stall_out_pct = 0;

  stim_row_t stim_tbl[TABLE_ROWS];

  longest_increasing_subsequence_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_element   (out_element),
    .out_position  (out_position),
    .out_lis_length(out_lis_length),
    .out_dropped   (out_dropped),
    .out_last_out  (out_last_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold valid and payload until the core takes the transaction
  task automatic send_item(input logic [VW-1:0] v, input logic l);
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Track the loaded sequence; on the last mark, solve it and queue the subsequence
  task automatic absorb_item(input logic [VW-1:0] v, input logic l, input bit push_results);
    int          run_len[DEPTH];
    int          pick[DEPTH];
    int          n;
    int          best;
    int          first;
    int          want;
    int          k;
    lis_result_t res;
    if (loaded_vals.size() < DEPTH) loaded_vals.push_back(v);
    else store_overflow = 1'b1;
    if (l) begin
      n = loaded_vals.size();
      for (int i = 0; i < n; i++) run_len[i] = 1;
      for (int i = 0; i + 1 < n; i++)
        for (int j = i + 1; j < n; j++)
          if (loaded_vals[j] > loaded_vals[i] && run_len[j] < run_len[i] + 1)
            run_len[j] = run_len[i] + 1;
      best = run_len[0];
      for (int i = 1; i < n; i++)
        if (best < run_len[i]) best = run_len[i];
      first = 0;
      while (first < n && run_len[first] != best) first++;
      // Walk down from the first peak, taking each position at the wanted length
      want = best;
      k = best;
      for (int i = first; i >= 0; i--) begin
        if (want > 0 && run_len[i] == want) begin
          k--;
          pick[k] = i;
          want--;
        end
      end
      if (push_results) begin
        for (int m = 0; m < best; m++) begin
          res.element    = loaded_vals[pick[m]];
          res.position   = IW'(pick[m]);
          res.lis_length = LW'(best);
          res.dropped    = store_overflow;
          res.last_out   = (m + 1 == best);
          lis_expect_q.push_back(res);
        end
      end
      loaded_vals.delete();
      store_overflow = 1'b0;
    end
  endtask

  // Check every result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    lis_result_t expd;
    if (rst_n && out_valid && out_ready) begin
      if (lis_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result element=%0d position=%0d length=%0d",
                   $signed(out_element), out_position, out_lis_length);
      end else begin
        expd = lis_expect_q.pop_front();
        if (out_element !== expd.element || out_position !== expd.position ||
            out_lis_length !== expd.lis_length || out_dropped !== expd.dropped ||
            out_last_out !== expd.last_out) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"ERROR: exp el=%0d pos=%0d len=%0d drop=%0b last=%0b, ",
                      "got el=%0d pos=%0d len=%0d drop=%0b last=%0b"},
                     $signed(expd.element), expd.position, expd.lis_length, expd.dropped,
                     expd.last_out, $signed(out_element), out_position, out_lis_length,
                     out_dropped, out_last_out);
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= stall_out_pct);
  end

  initial begin
    int            rand_items;
    int            seq_idx;
    int            seq_len;
    int            mode;
    int            r;
    logic [VW-1:0] v;

    // Directed sequences: single values, decreasing, equal, increasing, mixed
    stim_tbl[0]  = '{VAL_MIN,  1'b1, 1'b1, '{VAL_MIN,  '0, LW'(1), 1'b0, 1'b1}};
    stim_tbl[1]  = '{VAL_MAX,  1'b1, 1'b1, '{VAL_MAX,  '0, LW'(1), 1'b0, 1'b1}};
    stim_tbl[2]  = '{VAL_NEG1, 1'b1, 1'b1, '{VAL_NEG1, '0, LW'(1), 1'b0, 1'b1}};
    stim_tbl[3]  = '{VW'(5), 1'b0, 1'b0, '0};
    stim_tbl[4]  = '{VW'(4), 1'b0, 1'b0, '0};
    stim_tbl[5]  = '{VW'(3), 1'b0, 1'b0, '0};
    stim_tbl[6]  = '{VW'(2), 1'b0, 1'b0, '0};
    stim_tbl[7]  = '{VW'(1), 1'b1, 1'b0, '0};
    stim_tbl[8]  = '{VW'(7), 1'b0, 1'b0, '0};
    stim_tbl[9]  = '{VW'(7), 1'b0, 1'b0, '0};
    stim_tbl[10] = '{VW'(7), 1'b1, 1'b0, '0};
    stim_tbl[11] = '{VAL_MIN,  1'b0, 1'b0, '0};
    stim_tbl[12] = '{VAL_NEG1, 1'b0, 1'b0, '0};
    stim_tbl[13] = '{VW'(0),   1'b0, 1'b0, '0};
    stim_tbl[14] = '{VW'(1),   1'b0, 1'b0, '0};
    stim_tbl[15] = '{VAL_MAX,  1'b1, 1'b0, '0};
    stim_tbl[16] = '{VW'(3),   1'b0, 1'b0, '0};
    stim_tbl[17] = '{-VW'(2),  1'b0, 1'b0, '0};
    stim_tbl[18] = '{VW'(8),   1'b0, 1'b0, '0};
    stim_tbl[19] = '{VW'(1),   1'b0, 1'b0, '0};
    stim_tbl[20] = '{VW'(9),   1'b0, 1'b0, '0};
    stim_tbl[21] = '{VW'(4),   1'b1, 1'b0, '0};
    stim_tbl[22] = '{VW'(0),   1'b1, 1'b1, '{VW'(0), '0, LW'(1), 1'b0, 1'b1}};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int t = 0; t < TABLE_ROWS; t++) begin
      send_item(stim_tbl[t].value, stim_tbl[t].last);
      absorb_item(stim_tbl[t].value, stim_tbl[t].last, !stim_tbl[t].typed);
      if (stim_tbl[t].typed) lis_expect_q.push_back(stim_tbl[t].res);
    end

    // Random sequences; force one exactly full store and one overflowing store
    rand_items = 0;
    seq_idx = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (seq_idx == 2) seq_len = DEPTH;
      else if (seq_idx == 7) seq_len = DEPTH + 3;
      else begin
        r = $urandom_range(0, 99);
        if (r < 4) seq_len = $urandom_range(DEPTH + 1, DEPTH + 6);
        else if (r < 12) seq_len = $urandom_range(13, 40);
        else seq_len = $urandom_range(1, 12);
      end
      mode = $urandom_range(0, 9);
      for (int k = 0; k < seq_len; k++) begin
        // Advance flow-control phase with the item count
        case (rand_items * 4 / RANDOM_ITEMS)
          0:       begin idle_in_pct = 0;  stall_out_pct = 0;  end
          1:       begin idle_in_pct = 63; stall_out_pct = 0;  end
          2:       begin idle_in_pct = 0;  stall_out_pct = 63; end
          default: begin idle_in_pct = 20; stall_out_pct = 20; end
        endcase
        if (mode < 6) v = VW'(int'($urandom_range(0, 16)) - 8);
        else if (mode < 9) v = VW'($urandom);
        else begin
          case ($urandom_range(0, 4))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            2:       v = VAL_NEG1;
            3:       v = VW'(1);
            default: v = '0;
          endcase
        end
        send_item(v, k == seq_len - 1);
        absorb_item(v, k == seq_len - 1, 1'b1);
        rand_items++;
      end
      seq_idx++;
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then settle
    while (lis_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3200000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
src/lisc_pkg.sv
src/lisc_ram.sv
src/lisc_seq.sv
src/longest_increasing_subsequence_core.sv
dv/tb_longest_increasing_subsequence_core.sv
